@@ sv/dfr_pkg.sv @@
// ----------------------------------------------------------------------------
// dfr_pkg
// Shared types and constants for the delimited frame receiver.
// ----------------------------------------------------------------------------
package dfr_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_LEN_HI  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_FOOTER  = 3'd4
  } phase_t;

  localparam logic       REG_HEADER   = 1'b0;
  localparam logic       REG_FOOTER   = 1'b1;
  localparam logic [31:0] HEADER_RESET = 32'hFAFB_FCFD;
  localparam logic [31:0] FOOTER_RESET = 32'h0102_0304;

  localparam logic       FUNC_RX   = 1'b0;
  localparam logic       FUNC_READ = 1'b1;

  typedef struct packed {
    logic   frame_done;
    logic   store_we;
    phase_t phase;
  } dfr_ctrl_t;

endpackage

@@ sv/dfr_if.sv @@
// ----------------------------------------------------------------------------
// dfr_in_if / dfr_out_if
// Valid/ready channels for received beats and result beats.
// ----------------------------------------------------------------------------
interface dfr_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;
  logic [5:0] read_index;

  modport source (output valid, func, rx_byte, read_index, input ready);
  modport sink   (input valid, func, rx_byte, read_index, output ready);
endinterface

interface dfr_out_if;
  logic       valid;
  logic       ready;
  logic       frame_done;
  logic [5:0] frame_length;
  logic [7:0] read_byte;
  logic [2:0] rx_phase;

  modport source (output valid, frame_done, frame_length, read_byte, rx_phase, input ready);
  modport sink   (input valid, frame_done, frame_length, read_byte, rx_phase, output ready);
endinterface

@@ sv/dfr_frame_fsm.sv @@
// ----------------------------------------------------------------------------
// dfr_frame_fsm
// Frame parser: delimiter match, length capture, payload count, footer match.
// ----------------------------------------------------------------------------
module dfr_frame_fsm
  import dfr_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [31:0]                     cfg_wdata,
  input  logic                            rx_beat,
  input  logic [7:0]                      rx_byte,
  output dfr_ctrl_t                       ctrl,
  output logic [$clog2(BUFFER_BYTES)-1:0] store_addr,
  output logic [$clog2(BUFFER_BYTES)-1:0] completed_len_nxt
);

  localparam int          AW        = $clog2(BUFFER_BYTES);
  localparam logic [15:0] BUF_LIMIT = 16'(BUFFER_BYTES);

  phase_t          phase_r, phase_nxt;
  logic [31:0]     header_r, footer_r;
  logic [31:0]     shift_r, shift_nxt;
  logic [7:0]      len_lo_r, len_lo_nxt;
  logic [AW-1:0]   decl_r, decl_nxt;
  logic [AW-1:0]   count_r, count_nxt;
  logic [AW-1:0]   completed_r;
  logic [31:0]     shifted;
  logic [15:0]     full_len;
  logic            byte_match;
  logic            hunt;
  logic            done;
  logic            we;

  assign shifted    = shift_r >> 8;
  assign byte_match = (rx_byte == shift_r[7:0]);
  assign full_len   = {rx_byte, len_lo_r};

  always_comb begin
    phase_nxt  = phase_r;
    shift_nxt  = shift_r;
    len_lo_nxt = len_lo_r;
    decl_nxt   = decl_r;
    count_nxt  = count_r;
    hunt       = 1'b0;
    done       = 1'b0;
    we         = 1'b0;
    if (rx_beat) begin
      unique case (phase_r)
        PH_HEADER: begin
          if (byte_match) begin
            shift_nxt = shifted;
            if (shifted == 32'd0) phase_nxt = PH_LEN_LO;
          end else begin
            hunt = 1'b1;
          end
        end
        PH_LEN_LO: begin
          len_lo_nxt = rx_byte;
          phase_nxt  = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          if (full_len >= BUF_LIMIT) begin
            hunt = 1'b1;
          end else begin
            decl_nxt  = AW'(full_len);
            shift_nxt = footer_r;
            count_nxt = '0;
            phase_nxt = (full_len != 16'd0) ? PH_PAYLOAD : PH_FOOTER;
          end
        end
        PH_PAYLOAD: begin
          we        = 1'b1;
          count_nxt = count_r + AW'(1);
          if (count_nxt >= decl_r) phase_nxt = PH_FOOTER;
        end
        PH_FOOTER: begin
          if (byte_match) begin
            shift_nxt = shifted;
            if (shifted == 32'd0) begin
              done = 1'b1;
              hunt = 1'b1;
            end
          end else begin
            hunt = 1'b1;
          end
        end
        default: hunt = 1'b1;
      endcase
    end
    if (hunt) begin
      phase_nxt = PH_HEADER;
      shift_nxt = header_r;
      count_nxt = '0;
    end
  end

  assign completed_len_nxt = done ? decl_r : completed_r;
  assign store_addr        = count_r;
  assign ctrl.frame_done   = done;
  assign ctrl.store_we     = we;
  assign ctrl.phase        = phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      header_r    <= HEADER_RESET;
      footer_r    <= FOOTER_RESET;
      shift_r     <= HEADER_RESET;
      completed_r <= '0;
      count_r     <= '0;
    end else if (cfg_we) begin
      phase_r <= PH_HEADER;
      count_r <= '0;
      if (cfg_index == REG_HEADER) begin
        header_r <= cfg_wdata;
        shift_r  <= cfg_wdata;
      end else begin
        footer_r <= cfg_wdata;
        shift_r  <= header_r;
      end
    end else begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      completed_r <= completed_len_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_lo_r <= len_lo_nxt;
    decl_r   <= decl_nxt;
  end

endmodule

@@ sv/delimited_frame_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// delimited_frame_receiver_unit
// Length-prefixed deframer with payload store and read-back.
// ----------------------------------------------------------------------------
// Each input beat loads the result register; its result beat follows in the next cycle.
// Throughput: one beat per cycle; in ready = no result held or result taken.
// Payload store: one write and one registered read port, one access per beat.
// Reset: synchronous, active low; parser to header hunting, registers to
// defaults, last length to zero; the payload store is not cleared.
module delimited_frame_receiver_unit
  import dfr_pkg::*;
#(
  parameter int BUFFER_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  dfr_in_if.sink      in_ch,
  dfr_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int CW = (AW > 6) ? AW : 6;

  logic [7:0]    mem [BUFFER_BYTES];
  dfr_ctrl_t     ctrl;
  logic [AW-1:0] store_addr;
  logic [AW-1:0] completed_len_nxt;
  logic [AW-1:0] rd_addr;
  logic          in_beat;
  logic          rx_beat;
  logic          rd_hit;

  logic          out_valid_r;
  logic          frame_done_r;
  logic [5:0]    frame_length_r;
  logic [7:0]    read_byte_r;
  logic [2:0]    rx_phase_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign rx_beat     = in_beat && (in_ch.func == FUNC_RX);
  assign rd_addr     = AW'(in_ch.read_index);
  assign rd_hit      = (in_ch.func == FUNC_READ) &&
                       (CW'(in_ch.read_index) < CW'(completed_len_nxt));

  dfr_frame_fsm #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_fsm (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .rx_beat           (rx_beat),
    .rx_byte           (in_ch.rx_byte),
    .ctrl              (ctrl),
    .store_addr        (store_addr),
    .completed_len_nxt (completed_len_nxt)
  );

  always_ff @(posedge clk) begin
    if (ctrl.store_we) mem[store_addr] <= in_ch.rx_byte;
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      read_byte_r    <= rd_hit ? mem[rd_addr] : 8'd0;
      frame_done_r   <= ctrl.frame_done;
      frame_length_r <= 6'(completed_len_nxt);
      rx_phase_r     <= 3'(ctrl.phase);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_beat) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_done   = frame_done_r;
  assign out_ch.frame_length = frame_length_r;
  assign out_ch.read_byte    = read_byte_r;
  assign out_ch.rx_phase     = rx_phase_r;

endmodule
